[sv/rale_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rale_pkg: shared definitions of the repeat-accumulate parity encoder
// Code sizes, derived memory geometry, item kinds, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rale_pkg;

	// Code geometry
	localparam int INFO_BITS   = 2064;
	localparam int PARITY_BITS = 516;
	localparam int ROW_WEIGHT  = 12;

	localparam int TABLE_DEPTH = PARITY_BITS * ROW_WEIGHT;
	localparam int INFO_BYTES  = (INFO_BITS + 7) / 8;
	localparam int WORD_COUNT  = (PARITY_BITS + 15) / 16;

	// Address and counter widths
	localparam int TADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IADDR_W = (INFO_BYTES > 1) ? $clog2(INFO_BYTES) : 1;
	localparam int POS_W   = (ROW_WEIGHT > 1) ? $clog2(ROW_WEIGHT) : 1;

	// Fixed field widths
	localparam int KIND_W   = 1;
	localparam int TIDX_W   = 13;
	localparam int TVAL_W   = 12;
	localparam int BIDX_W   = 9;
	localparam int BYTE_W   = 8;
	localparam int WORD_W   = 16;
	localparam int WIDX_W   = 6;
	localparam int FILL_W   = 4;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_TABLE = 1'b0;
	localparam logic [KIND_W-1:0] KIND_BYTE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;   // start of a block: reset accumulator and counters
		logic issue;   // read the next row table slot
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic adv;         // pipeline may advance this cycle
		logic issue_last;  // read address sits at the final table slot
		logic done;        // final parity word loaded into the output register
	} dp_status_t;

endpackage

[sv/rale_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rale_in_if: input item channel
// Valid/ready channel carrying one table entry or one information byte.
// ----------------------------------------------------------------------------
interface rale_in_if;
	import rale_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [TIDX_W-1:0]   table_index;
	logic [TVAL_W-1:0]   table_value;
	logic [BIDX_W-1:0]   byte_index;
	logic [BYTE_W-1:0]   data_byte;
	logic                last_byte;

	modport source (
		output valid, kind, table_index, table_value, byte_index, data_byte,
			last_byte,
		input  ready
	);

	modport sink (
		input  valid, kind, table_index, table_value, byte_index, data_byte,
			last_byte,
		output ready
	);

endinterface

[sv/rale_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rale_out_if: parity word channel
// Valid/ready channel carrying one 16-bit parity word and its position.
// ----------------------------------------------------------------------------
interface rale_out_if;
	import rale_pkg::*;

	logic                valid;
	logic                ready;
	logic [WORD_W-1:0]   parity_word;
	logic [WIDX_W-1:0]   word_index;
	logic                last_word;

	modport source (
		output valid, parity_word, word_index, last_word,
		input  ready
	);

	modport sink (
		input  valid, parity_word, word_index, last_word,
		output ready
	);

endinterface

[sv/rale_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rale_ram: generic simple dual-port RAM
// One write port, one read port with a registered, enable-held read data.
// ----------------------------------------------------------------------------
module rale_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/rale_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rale_ctrl: encoder controller
// Accepts items while idle, then sequences the table sweep and waits for the
// final parity word before returning to idle.
// ----------------------------------------------------------------------------
module rale_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_start,   // byte item carrying the last mark
	output logic                 in_ready,
	output rale_pkg::dp_cmd_t    cmd,
	input  rale_pkg::dp_status_t status
);
	import rale_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd.clear = 1'b0;
		cmd.issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_start) begin
					cmd.clear = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (status.adv && status.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Input is taken only while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("rale_ctrl: input ready outside idle");

	// No table read is issued while draining
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !cmd.issue)
		else $error("rale_ctrl: table read issued while draining");

endmodule

[sv/rale_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rale_dp: encoder datapath
// Row table and information memories, a three-step read pipeline
// (table slot, information byte, bit select and accumulate), the parity
// shift register and the output word register.
// ----------------------------------------------------------------------------
module rale_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,   // input item accepted
	input  logic [rale_pkg::KIND_W-1:0] kind,
	input  logic [rale_pkg::TIDX_W-1:0] table_index,
	input  logic [rale_pkg::TVAL_W-1:0] table_value,
	input  logic [rale_pkg::BIDX_W-1:0] byte_index,
	input  logic [rale_pkg::BYTE_W-1:0] data_byte,
	input  rale_pkg::dp_cmd_t           cmd,
	output rale_pkg::dp_status_t        status,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rale_pkg::WORD_W-1:0] parity_word,
	output logic [rale_pkg::WIDX_W-1:0] word_index,
	output logic                        last_word
);
	import rale_pkg::*;

	logic                tbl_we;
	logic                info_we;
	logic                adv;
	logic                issue;
	logic                row_end;
	logic                addr_last;
	logic [TVAL_W-1:0]   tbl_rdata;
	logic [BYTE_W-1:0]   info_rdata;
	logic                tbl_hit;
	logic [IADDR_W-1:0]  info_raddr;
	logic                info_bit;
	logic                acc_next;
	logic [WORD_W-1:0]   shift_next;
	logic                emit;

	logic [TADDR_W-1:0]  rd_addr_q;
	logic [POS_W-1:0]    pos_q;
	logic                valid_s1;
	logic                row_end_s1;
	logic                last_s1;
	logic                valid_s2;
	logic                row_end_s2;
	logic                last_s2;
	logic                hit_s2;
	logic [2:0]          bitpos_s2;
	logic                acc_q;
	logic [WORD_W-1:0]   shift_q;
	logic [FILL_W-1:0]   fill_q;
	logic [WIDX_W-1:0]   word_idx_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   word_q;
	logic [WIDX_W-1:0]   widx_q;
	logic                wlast_q;

	// Memory writes from accepted items, out-of-range slots dropped
	assign tbl_we  = load && (kind == KIND_TABLE) && (32'(table_index) < TABLE_DEPTH);
	assign info_we = load && (kind == KIND_BYTE) && (32'(byte_index) < INFO_BYTES);

	// Freeze the whole pipeline while a finished word waits
	assign adv   = !out_valid_q || out_ready;
	assign issue = cmd.issue && adv;

	assign row_end   = (32'(pos_q) == ROW_WEIGHT - 1);
	assign addr_last = (32'(rd_addr_q) == TABLE_DEPTH - 1);

	rale_ram #(
		.WIDTH (TVAL_W),
		.DEPTH (TABLE_DEPTH)
	) u_row_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (TADDR_W'(table_index)),
		.wdata (table_value),
		.re    (issue),
		.raddr (rd_addr_q),
		.rdata (tbl_rdata)
	);

	// Table value selects one information byte; out-of-range indices give zero
	assign tbl_hit    = (32'(tbl_rdata) < INFO_BITS);
	assign info_raddr = tbl_hit ? IADDR_W'(tbl_rdata >> 3) : '0;

	rale_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (INFO_BYTES)
	) u_info_store (
		.clk   (clk),
		.we    (info_we),
		.waddr (IADDR_W'(byte_index)),
		.wdata (data_byte),
		.re    (valid_s1 && adv),
		.raddr (info_raddr),
		.rdata (info_rdata)
	);

	// Pick the indexed bit (MSB first) and fold it into the accumulator
	assign info_bit   = hit_s2 && info_rdata[3'd7 - bitpos_s2];
	assign acc_next   = acc_q ^ info_bit;
	assign shift_next = {shift_q[WORD_W-2:0], acc_next};
	assign emit       = valid_s2 && adv && row_end_s2 && ((fill_q == '1) || last_s2);

	// Read address and row position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			pos_q     <= '0;
		end else if (cmd.clear) begin
			rd_addr_q <= '0;
			pos_q     <= '0;
		end else if (issue) begin
			rd_addr_q <= rd_addr_q + TADDR_W'(1);
			pos_q     <= row_end ? '0 : pos_q + POS_W'(1);
		end
	end

	// Pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			row_end_s1 <= row_end;
			last_s1    <= addr_last;
			row_end_s2 <= row_end_s1;
			last_s2    <= last_s1;
			hit_s2     <= tbl_hit;
			bitpos_s2  <= tbl_rdata[2:0];
		end
	end

	// Accumulate, shift parity bits in and count words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= 1'b0;
			shift_q    <= '0;
			fill_q     <= '0;
			word_idx_q <= '0;
		end else if (cmd.clear) begin
			acc_q      <= 1'b0;
			shift_q    <= '0;
			fill_q     <= '0;
			word_idx_q <= '0;
		end else if (valid_s2 && adv) begin
			acc_q <= acc_next;
			if (emit) begin
				shift_q    <= '0;
				fill_q     <= '0;
				word_idx_q <= word_idx_q + WIDX_W'(1);
			end else if (row_end_s2) begin
				shift_q <= shift_next;
				fill_q  <= fill_q + FILL_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Left-align a short final word, zero-padded
	always_ff @(posedge clk) begin
		if (emit) begin
			word_q  <= shift_next << (FILL_W'(15) - fill_q);
			widx_q  <= word_idx_q;
			wlast_q <= last_s2;
		end
	end

	assign status.adv        = adv;
	assign status.issue_last = addr_last;
	assign status.done       = emit && last_s2;

	assign out_valid   = out_valid_q;
	assign parity_word = word_q;
	assign word_index  = widx_q;
	assign last_word   = wlast_q;

	// The final parity bit closes a row
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && last_s2) |-> row_end_s2)
		else $error("rale_dp: final slot not at a row end");

	// The final word carries the last word position
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_s2) |-> (32'(word_idx_q) == ((WORD_COUNT - 1) % (1 << WIDX_W))))
		else $error("rale_dp: final word at wrong position");

	// A stalled step keeps its pending bit
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv) |=> (valid_s2 && $stable(bitpos_s2) && $stable(acc_q)))
		else $error("rale_dp: stalled step lost");

	// A word is never loaded over one that waits
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(word_q)))
		else $error("rale_dp: pending word overwritten");

endmodule

[sv/ra_ldpc_parity_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ra_ldpc_parity_encoder: repeat-accumulate LDPC parity encoder
// Loads a parity-row table and one block of information bytes, then sweeps
// the table once and emits the parity bits as 16-bit words, MSB first.
// ----------------------------------------------------------------------------
// Table entries and information bytes are taken one per cycle while idle.
// The byte marked last starts a sweep of 6192 table slots, one read per cycle
// while no finished word waits; no new item is taken until the final parity
// word has been loaded into the output register.
// The pipeline holds whenever a finished word waits at the output. Reset clears
// the controller, counters and output valid; memories are written before use.
module ra_ldpc_parity_encoder (
	input  logic       clk,
	input  logic       arst_n,
	rale_in_if.sink    info,
	rale_out_if.source parity
);
	import rale_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       load;

	assign load = info.valid && info.ready;

	rale_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (info.valid),
		.in_start ((info.kind == KIND_BYTE) && info.last_byte),
		.in_ready (info.ready),
		.cmd      (cmd),
		.status   (status)
	);

	rale_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.kind        (info.kind),
		.table_index (info.table_index),
		.table_value (info.table_value),
		.byte_index  (info.byte_index),
		.data_byte   (info.data_byte),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (parity.valid),
		.out_ready   (parity.ready),
		.parity_word (parity.parity_word),
		.word_index  (parity.word_index),
		.last_word   (parity.last_word)
	);

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the repeat-accumulate parity encoder
// Fills the whole row table and the information block first. A directed
// table of items comes next, with some results typed in by hand. Random
// blocks follow, checked against a parity encoder that the bench keeps.
// Both channels idle in random bursts, and the parity side holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import rale_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 230;
	localparam int QUIET_ITEMS  = 40;
	localparam int HOLD_AT_WORD = 40;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 5000;
	localparam int MAX_REPORTS  = 50;
	localparam int TVAL_MAX     = (1 << TVAL_W) - 1;
	localparam int TIDX_MAX     = (1 << TIDX_W) - 1;
	localparam int BIDX_MAX     = (1 << BIDX_W) - 1;

	// How the expected parity words of a directed row are obtained
	typedef enum logic [1:0] {
		SHAPE_MODEL,
		SHAPE_NONE,
		SHAPE_ZERO,
		SHAPE_ONES
	} shape_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [TIDX_W-1:0] table_index;
		logic [TVAL_W-1:0] table_value;
		logic [BIDX_W-1:0] byte_index;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} info_item_t;

	typedef struct {
		logic [WORD_W-1:0] parity_word;
		logic [WIDX_W-1:0] word_index;
		logic              last_word;
	} parity_item_t;

	typedef struct {
		info_item_t item;
		shape_t     shape;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rale_in_if  info_ch ();
	rale_out_if parity_ch ();

	ra_ldpc_parity_encoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.info   (info_ch),
		.parity (parity_ch)
	);

	// Bench copy of the encoder state
	logic [TVAL_W-1:0] row_slots [TABLE_DEPTH];
	logic [BYTE_W-1:0] info_bytes [INFO_BYTES];
	parity_item_t      parity_due [$];
	dir_row_t          dir_rows [$];

	int fail_count  = 0;
	int words_taken = 0;
	int idle_cycles = 0;
	bit quiet       = 1'b0;

	// Clock
	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	function automatic info_item_t make_item(input int kind, input int tidx, input int tval,
			input int bidx, input int dbyte, input int last);
		info_item_t it;
		it.kind        = kind[KIND_W-1:0];
		it.table_index = tidx[TIDX_W-1:0];
		it.table_value = tval[TVAL_W-1:0];
		it.byte_index  = bidx[BIDX_W-1:0];
		it.data_byte   = dbyte[BYTE_W-1:0];
		it.last_byte   = last[0];
		return it;
	endfunction

	function automatic dir_row_t dir_row(input int kind, input int tidx, input int tval,
			input int bidx, input int dbyte, input int last, input shape_t shape);
		dir_row_t r;
		r.item  = make_item(kind, tidx, tval, bidx, dbyte, last);
		r.shape = shape;
		return r;
	endfunction

	// Apply one item to the bench state; on a last byte, sweep the table and
	// queue the parity words when asked to
	task automatic encode_item(input info_item_t it, input bit push);
		logic              acc;
		logic [WORD_W-1:0] shift;
		parity_item_t      w;
		int                v;
		int                n;
		if (it.kind == KIND_TABLE) begin
			if (it.table_index < TABLE_DEPTH)
				row_slots[it.table_index] = it.table_value;
		end else begin
			if (it.byte_index < INFO_BYTES)
				info_bytes[it.byte_index] = it.data_byte;
			if (it.last_byte && push) begin
				acc   = 1'b0;
				shift = '0;
				n     = 0;
				for (int p = 0; p < PARITY_BITS; p++) begin
					for (int k = 0; k < ROW_WEIGHT; k++) begin
						v = row_slots[p * ROW_WEIGHT + k];
						// bit 0 of the block is the MSB of byte 0
						if (v < INFO_BITS)
							acc ^= info_bytes[v / 8][7 - v % 8];
					end
					shift = {shift[WORD_W-2:0], acc};
					if (p % WORD_W == WORD_W - 1 || p == PARITY_BITS - 1) begin
						w.parity_word = shift << (WORD_W - 1 - p % WORD_W);
						w.word_index  = n[WIDX_W-1:0];
						w.last_word   = (p == PARITY_BITS - 1);
						parity_due.push_back(w);
						n++;
						shift = '0;
					end
				end
			end
		end
	endtask

	// Queue a block of all-zero or all-one parity bits, final word padded
	task automatic expect_flat(input bit ones);
		parity_item_t w;
		for (int n = 0; n < WORD_COUNT; n++) begin
			w.word_index  = n[WIDX_W-1:0];
			w.last_word   = (n == WORD_COUNT - 1);
			w.parity_word = !ones ? 16'h0000 : (w.last_word ? 16'hF000 : 16'hFFFF);
			parity_due.push_back(w);
		end
	endtask

	// Offer one item at the falling edge, hold it until it is taken
	task automatic send_item(input info_item_t it, input shape_t shape);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			info_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		info_ch.valid       <= 1'b1;
		info_ch.kind        <= it.kind;
		info_ch.table_index <= it.table_index;
		info_ch.table_value <= it.table_value;
		info_ch.byte_index  <= it.byte_index;
		info_ch.data_byte   <= it.data_byte;
		info_ch.last_byte   <= it.last_byte;
		do @(posedge clk); while (info_ch.ready !== 1'b1);
		encode_item(it, shape == SHAPE_MODEL);
		if (shape == SHAPE_ZERO || shape == SHAPE_ONES)
			expect_flat(shape == SHAPE_ONES);
	endtask

	// Stimulus
	initial begin
		info_item_t it;
		int         counted;
		int         since_last;
		int         gap;
		int         pick;
		int         tval;
		info_ch.valid       = 1'b0;
		info_ch.kind        = KIND_TABLE;
		info_ch.table_index = '0;
		info_ch.table_value = '0;
		info_ch.byte_index  = '0;
		info_ch.data_byte   = '0;
		info_ch.last_byte   = 1'b0;
		parity_ch.ready     = 1'b0;
		arst_n              = 1'b0;
		foreach (row_slots[s])
			row_slots[s] = '0;
		foreach (info_bytes[b])
			info_bytes[b] = '0;

		// Directed rows. The table starts filled with out-of-range values,
		// so only the slots written here contribute.
		// all contributions zero
		dir_rows.push_back(dir_row(KIND_BYTE, 0, 0, 257, 'hFF, 1, SHAPE_ZERO));
		// table slots past the end are ignored, byte fields too
		dir_rows.push_back(dir_row(KIND_TABLE, TIDX_MAX, 0, BIDX_MAX, 'hFF, 1, SHAPE_NONE));
		dir_rows.push_back(dir_row(KIND_TABLE, TABLE_DEPTH, 0, 0, 'h00, 1, SHAPE_NONE));
		// dropped byte still starts the sweep, table fields ignored
		dir_rows.push_back(dir_row(KIND_BYTE, TIDX_MAX, TVAL_MAX, BIDX_MAX, 'h00, 1,
			SHAPE_ZERO));
		// first slot reads bit 0, the accumulator carries it to every row
		dir_rows.push_back(dir_row(KIND_TABLE, 0, 0, 0, 'h00, 0, SHAPE_NONE));
		dir_rows.push_back(dir_row(KIND_BYTE, 0, 0, 0, 'hFF, 1, SHAPE_ONES));
		dir_rows.push_back(dir_row(KIND_BYTE, TIDX_MAX, TVAL_MAX, 0, 'h7F, 1, SHAPE_ZERO));
		dir_rows.push_back(dir_row(KIND_BYTE, 0, 0, INFO_BYTES, 'h80, 1, SHAPE_ZERO));
		dir_rows.push_back(dir_row(KIND_BYTE, 0, 0, 0, 'h80, 0, SHAPE_NONE));
		dir_rows.push_back(dir_row(KIND_BYTE, 0, 0, 300, 'h00, 1, SHAPE_ONES));
		// final slot reads the final information bit
		dir_rows.push_back(dir_row(KIND_TABLE, TABLE_DEPTH - 1, INFO_BITS - 1, 0, 0, 0,
			SHAPE_NONE));
		dir_rows.push_back(dir_row(KIND_BYTE, 0, 0, INFO_BYTES - 1, 'h01, 1, SHAPE_MODEL));
		// first out-of-range bit index contributes nothing
		dir_rows.push_back(dir_row(KIND_TABLE, 0, INFO_BITS, 0, 0, 0, SHAPE_NONE));
		dir_rows.push_back(dir_row(KIND_BYTE, 0, 0, INFO_BYTES - 1, 'h00, 1, SHAPE_ZERO));
		dir_rows.push_back(dir_row(KIND_TABLE, ROW_WEIGHT, 7, 0, 0, 0, SHAPE_NONE));
		dir_rows.push_back(dir_row(KIND_BYTE, 0, 0, 0, 'h01, 1, SHAPE_MODEL));
		dir_rows.push_back(dir_row(KIND_TABLE, TABLE_DEPTH - ROW_WEIGHT, INFO_BITS - 8, 0, 0,
			1, SHAPE_NONE));
		dir_rows.push_back(dir_row(KIND_TABLE, 5000, 1024, 0, 0, 0, SHAPE_NONE));
		dir_rows.push_back(dir_row(KIND_BYTE, 0, 0, 128, 'hAA, 0, SHAPE_NONE));
		dir_rows.push_back(dir_row(KIND_BYTE, TIDX_MAX, 0, INFO_BYTES - 1, 'h80, 1,
			SHAPE_MODEL));

		// Release reset after a fixed count of rising edges
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill every table slot and every information byte before any sweep
		for (int s = 0; s < TABLE_DEPTH; s++)
			send_item(make_item(KIND_TABLE, s, TVAL_MAX, $urandom_range(0, BIDX_MAX),
				$urandom_range(0, 255), $urandom_range(0, 1)), SHAPE_MODEL);
		for (int b = 0; b < INFO_BYTES; b++)
			send_item(make_item(KIND_BYTE, $urandom_range(0, TIDX_MAX),
				$urandom_range(0, TVAL_MAX), b, 'hFF, 0), SHAPE_MODEL);

		// Walk the directed rows
		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].shape);

		// Random blocks: mostly new bytes and table entries, some ignored noise
		counted    = 0;
		since_last = 0;
		gap        = $urandom_range(15, 35);
		while (counted < RANDOM_ITEMS) begin
			if (counted >= RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			pick = $urandom_range(0, 99);
			tval = ($urandom_range(0, 7) == 0) ? $urandom_range(INFO_BITS, TVAL_MAX) :
				$urandom_range(0, INFO_BITS - 1);
			if (since_last >= gap || counted == RANDOM_ITEMS - 1) begin
				// close the block
				it = make_item(KIND_BYTE, $urandom, $urandom, $urandom_range(0, INFO_BYTES - 1),
					$urandom, 1);
				since_last = 0;
				gap        = $urandom_range(15, 35);
				counted++;
			end else if (pick < 55) begin
				it = make_item(KIND_BYTE, $urandom, $urandom, $urandom_range(0, INFO_BYTES - 1),
					$urandom, 0);
				since_last++;
				counted++;
			end else if (pick < 85) begin
				it = make_item(KIND_TABLE, $urandom_range(0, TABLE_DEPTH - 1), tval, $urandom,
					$urandom, $urandom);
				since_last++;
				counted++;
			end else if (pick < 93) begin
				it = make_item(KIND_TABLE, $urandom_range(TABLE_DEPTH, TIDX_MAX), $urandom,
					$urandom, $urandom, $urandom);
			end else begin
				it = make_item(KIND_BYTE, $urandom, $urandom,
					$urandom_range(INFO_BYTES, BIDX_MAX), $urandom, 0);
			end
			send_item(it, SHAPE_MODEL);
		end

		// Drain and finish
		@(negedge clk);
		info_ch.valid <= 1'b0;
		while (parity_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Parity side: random stall bursts and one long hold-off mid-block
	initial begin
		int stall_left;
		bit held;
		stall_left = 0;
		held       = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && words_taken >= HOLD_AT_WORD) begin
				held       = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 9);
			end
			if (stall_left > 0) begin
				parity_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				parity_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each parity word with the oldest one due
	always @(posedge clk) begin
		parity_item_t want;
		if (parity_ch.valid === 1'b1 && parity_ch.ready === 1'b1) begin
			words_taken++;
			if (parity_due.size() == 0) begin
				report_mismatch("parity word with nothing due", parity_ch.parity_word, 0);
			end else begin
				want = parity_due.pop_front();
				if (parity_ch.parity_word !== want.parity_word)
					report_mismatch($sformatf("word %0d parity_word", want.word_index),
						parity_ch.parity_word, want.parity_word);
				if (parity_ch.word_index !== want.word_index)
					report_mismatch($sformatf("word %0d word_index", want.word_index),
						parity_ch.word_index, want.word_index);
				if (parity_ch.last_word !== want.last_word)
					report_mismatch($sformatf("word %0d last_word", want.word_index),
						parity_ch.last_word, want.last_word);
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((info_ch.valid === 1'b1 && info_ch.ready === 1'b1) ||
				(parity_ch.valid === 1'b1 && parity_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
